>>> src/assert_macros.svh
// Assertion macros shared by the ray differential block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is high.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: implication does not hold");

// Value that must hold in the cycle after reset was seen high.
`define ASSERT_AFTER_RESET(label, clk, rst, cons) \
  label: assert property (@(posedge clk) (rst) |=> (cons)) \
    else $error("assertion failed: wrong value after reset");

`endif

>>> src/rdu_pkg.sv
// Types, widths and helper functions for the ray differential UV derivative block.
package rdu_pkg;

  localparam int COMP_BITS = 20;
  localparam int COMP_FRAC = 12;
  localparam int RES_FRAC  = 16;
  localparam int VEC_BITS  = 3 * COMP_BITS;
  localparam int TOL_BITS  = 19;
  localparam int RES_BITS  = 32;
  localparam int RES_QBITS = RES_BITS - 1;

  localparam int DOT_BITS  = 2 * COMP_BITS + 1;
  localparam int NUMT_BITS = 2 * COMP_BITS + 2;
  localparam int T_FRAC    = 2 * COMP_FRAC;
  localparam int T_QBITS   = 40;
  localparam int T_BITS    = T_QBITS + 1;
  localparam int PD_BITS   = COMP_BITS + T_BITS;
  localparam int OFF_BITS  = 2 * COMP_BITS + 1;
  localparam int DET_BITS  = 2 * COMP_BITS + 1;
  localparam int NP_BITS   = OFF_BITS + COMP_BITS;
  localparam int RNUM_BITS = NP_BITS + 1;

  localparam logic [TOL_BITS-1:0] TOL_RESET = TOL_BITS'(1);

  typedef logic signed [COMP_BITS-1:0] comp_t;

  typedef enum logic [1:0] {
    AXIS_XY,
    AXIS_XZ,
    AXIS_YZ
  } axis_t;

  typedef struct packed {
    comp_t                         o0;
    comp_t                         o1;
    comp_t                         d0;
    comp_t                         d1;
    logic signed [DOT_BITS-1:0]    den;
    logic signed [NUMT_BITS-1:0]   numt;
  } ray_t;

  typedef struct packed {
    logic  active;
    comp_t p0;
    comp_t p1;
    comp_t tu0;
    comp_t tu1;
    comp_t tv0;
    comp_t tv1;
    ray_t  rx;
    ray_t  ry;
  } item_t;

  typedef struct packed {
    logic  active;
    logic  par_x;
    comp_t p0;
    comp_t p1;
    comp_t tu0;
    comp_t tu1;
    comp_t tv0;
    comp_t tv1;
    comp_t ox0;
    comp_t ox1;
    comp_t dx0;
    comp_t dx1;
    comp_t oy0;
    comp_t oy1;
    comp_t dy0;
    comp_t dy1;
  } tside_t;

  function automatic comp_t get_comp(logic [VEC_BITS-1:0] v, logic [1:0] idx);
    return comp_t'(v[idx*COMP_BITS +: COMP_BITS]);
  endfunction

  function automatic logic [COMP_BITS-1:0] comp_mag(comp_t v);
    return v[COMP_BITS-1] ? COMP_BITS'(-v) : COMP_BITS'(v);
  endfunction

  // Component of v on the first or second projection axis.
  function automatic comp_t pick(logic [VEC_BITS-1:0] v, axis_t axis, logic second);
    logic [1:0] idx;
    unique case (axis)
      AXIS_XY: idx = second ? 2'd1 : 2'd0;
      AXIS_XZ: idx = second ? 2'd2 : 2'd0;
      AXIS_YZ: idx = second ? 2'd2 : 2'd1;
      default: idx = 2'd0;
    endcase
    return get_comp(v, idx);
  endfunction

endpackage

>>> src/ray_differential_uv_derivatives.sv
// Top level of the ray differential texture UV derivative block.
//
// Usage: one hit word enters on the in channel (in_valid/in_ready) carrying the
// hit and camera flags and eight packed Q8.12 vectors. One result word leaves on
// the out channel (out_valid/out_ready) for every hit word, in order: the flag
// derivs_valid and du/dx, dv/dx, du/dy, dv/dy in saturated Q16.16. When the
// derivatives cannot be formed (no hit, not a camera ray, zero determinant) the
// flag is low and the four fields are zero, so the consumer keeps its old ones.
// The axis tolerance is written on the cfg channel (cfg_valid/cfg_ready/cfg_data),
// which is always ready; it should only change while the block is empty.
// Throughput is one word per cycle while the receiver does not stall. The two
// pipelined long dividers hold 42 stages for the ray parameter and 33 for the
// final quotients; the front register, queue and product stages lie around them.
// A stalled receiver freezes the back end; the queue and the front register keep
// taking words until they fill, then in_ready drops. Reset empties every stage
// and sets the tolerance to one LSB.
`include "assert_macros.svh"

module ray_differential_uv_derivatives #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rdu_pkg::TOL_BITS-1:0]        cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                surface_hit,
  input  logic                                camera_ray,
  input  logic [rdu_pkg::VEC_BITS-1:0]        normal_vec,
  input  logic [rdu_pkg::VEC_BITS-1:0]        hit_point_vec,
  input  logic [rdu_pkg::VEC_BITS-1:0]        tangent_u_vec,
  input  logic [rdu_pkg::VEC_BITS-1:0]        tangent_v_vec,
  input  logic [rdu_pkg::VEC_BITS-1:0]        x_ray_origin_vec,
  input  logic [rdu_pkg::VEC_BITS-1:0]        x_ray_dir_vec,
  input  logic [rdu_pkg::VEC_BITS-1:0]        y_ray_origin_vec,
  input  logic [rdu_pkg::VEC_BITS-1:0]        y_ray_dir_vec,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                derivs_valid,
  output logic signed [rdu_pkg::RES_BITS-1:0] du_per_x,
  output logic signed [rdu_pkg::RES_BITS-1:0] dv_per_x,
  output logic signed [rdu_pkg::RES_BITS-1:0] du_per_y,
  output logic signed [rdu_pkg::RES_BITS-1:0] dv_per_y
);

  localparam int ITEM_W = $bits(rdu_pkg::item_t);
  localparam logic [rdu_pkg::RES_BITS-1:0] MOST_NEG = {1'b1, {(rdu_pkg::RES_BITS-1){1'b0}}};

  // The tolerance register is the only configuration state.
  logic [rdu_pkg::TOL_BITS-1:0] tol;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tol <= rdu_pkg::TOL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      tol <= cfg_data;
    end
  end

  logic              push_valid;
  logic              push_ready;
  rdu_pkg::item_t    push_item;
  logic              pop_valid;
  logic              pop_ready;
  logic [ITEM_W-1:0] pop_raw;

  rdu_front u_front (
    .clk, .rst,
    .in_valid, .in_ready,
    .surface_hit, .camera_ray,
    .normal_vec, .hit_point_vec, .tangent_u_vec, .tangent_v_vec,
    .x_ray_origin_vec, .x_ray_dir_vec, .y_ray_origin_vec, .y_ray_dir_vec,
    .tol,
    .push_valid, .push_ready,
    .item(push_item)
  );

  // Lets the front keep classifying while the back end is held by the receiver.
  rdu_queue #(
    .W(ITEM_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk, .rst,
    .wr_valid(push_valid), .wr_ready(push_ready), .wr_data(push_item),
    .rd_valid(pop_valid), .rd_ready(pop_ready), .rd_data(pop_raw)
  );

  rdu_back u_back (
    .clk, .rst,
    .pop_valid, .pop_ready,
    .item(rdu_pkg::item_t'(pop_raw)),
    .out_valid, .out_ready,
    .derivs_valid, .du_per_x, .dv_per_x, .du_per_y, .dv_per_y
  );

  // An unsolved word must carry zero derivatives.
  `ASSERT_IMPLY(a_zero_when_unsolved, clk, rst, out_valid && !derivs_valid, du_per_x == '0 && dv_per_x == '0 && du_per_y == '0 && dv_per_y == '0)
  // Saturation is symmetric, so the most negative code never appears.
  `ASSERT_IMPLY(a_symmetric_sat, clk, rst, out_valid, du_per_x != MOST_NEG && dv_per_x != MOST_NEG && du_per_y != MOST_NEG && dv_per_y != MOST_NEG)
  // Reset empties the pipeline and frees the input.
  `ASSERT_AFTER_RESET(a_reset_empty, clk, rst, !out_valid && in_ready)

endmodule

>>> src/rdu_div.sv
// Pipelined restoring divider giving a saturated, truncated fixed-point quotient.
module rdu_div #(
  parameter int A_W    = 42,
  parameter int B_W    = 41,
  parameter int Q_W    = 40,
  parameter int FRAC   = 24,
  parameter int SIDE_W = 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic [A_W-1:0]      a,
  input  logic [B_W-1:0]      b,
  input  logic                neg,
  input  logic [SIDE_W-1:0]   side,
  output logic                out_valid,
  output logic signed [Q_W:0] q,
  output logic [SIDE_W-1:0]   out_side
);

  localparam int SH = Q_W - FRAC;

  logic              v_s    [Q_W+1];
  logic              sat_s  [Q_W+1];
  logic              neg_s  [Q_W+1];
  logic [B_W-1:0]    b_s    [Q_W+1];
  logic [B_W-1:0]    rem_s  [Q_W+1];
  logic [Q_W-1:0]    bits_s [Q_W+1];
  logic [Q_W-1:0]    quo_s  [Q_W+1];
  logic [SIDE_W-1:0] side_s [Q_W+1];

  logic [A_W-1:0] hi;
  assign hi = a >> SH;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_s[0] <= 1'b0;
    end else if (en) begin
      v_s[0] <= in_valid;
    end
  end

  // The quotient overflows the limit exactly when the high part reaches the divisor.
  always_ff @(posedge clk) begin
    if (en) begin
      sat_s[0]  <= hi >= A_W'(b);
      neg_s[0]  <= neg;
      b_s[0]    <= b;
      rem_s[0]  <= hi[B_W-1:0];
      bits_s[0] <= {a[SH-1:0], {FRAC{1'b0}}};
      quo_s[0]  <= '0;
      side_s[0] <= side;
    end
  end

  for (genvar i = 0; i < Q_W; i++) begin : g_step
    logic [B_W:0] r2;
    logic [B_W:0] diff;
    logic         ge;
    assign r2   = {rem_s[i], bits_s[i][Q_W-1]};
    assign diff = r2 - {1'b0, b_s[i]};
    assign ge   = r2 >= {1'b0, b_s[i]};

    always_ff @(posedge clk) begin
      if (rst) begin
        v_s[i+1] <= 1'b0;
      end else if (en) begin
        v_s[i+1] <= v_s[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sat_s[i+1]  <= sat_s[i];
        neg_s[i+1]  <= neg_s[i];
        b_s[i+1]    <= b_s[i];
        rem_s[i+1]  <= ge ? diff[B_W-1:0] : r2[B_W-1:0];
        bits_s[i+1] <= bits_s[i] << 1;
        quo_s[i+1]  <= {quo_s[i][Q_W-2:0], ge};
        side_s[i+1] <= side_s[i];
      end
    end
  end

  logic signed [Q_W:0] mag;
  assign mag = sat_s[Q_W] ? $signed({1'b0, {Q_W{1'b1}}}) : $signed({1'b0, quo_s[Q_W]});

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v_s[Q_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q        <= neg_s[Q_W] ? -mag : mag;
      out_side <= side_s[Q_W];
    end
  end

endmodule

>>> src/rdu_front.sv
// Front end: accepts hit words, picks projection axes and forms the plane dot products.
module rdu_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          surface_hit,
  input  logic                          camera_ray,
  input  logic [rdu_pkg::VEC_BITS-1:0]  normal_vec,
  input  logic [rdu_pkg::VEC_BITS-1:0]  hit_point_vec,
  input  logic [rdu_pkg::VEC_BITS-1:0]  tangent_u_vec,
  input  logic [rdu_pkg::VEC_BITS-1:0]  tangent_v_vec,
  input  logic [rdu_pkg::VEC_BITS-1:0]  x_ray_origin_vec,
  input  logic [rdu_pkg::VEC_BITS-1:0]  x_ray_dir_vec,
  input  logic [rdu_pkg::VEC_BITS-1:0]  y_ray_origin_vec,
  input  logic [rdu_pkg::VEC_BITS-1:0]  y_ray_dir_vec,
  input  logic [rdu_pkg::TOL_BITS-1:0]  tol,
  output logic                          push_valid,
  input  logic                          push_ready,
  output rdu_pkg::item_t                item
);

  localparam int CB = rdu_pkg::COMP_BITS;

  logic f_valid;
  logic f_hit;
  logic f_cam;
  logic [rdu_pkg::VEC_BITS-1:0] f_n, f_p, f_tu, f_tv, f_ox, f_dx, f_oy, f_dy;

  assign push_valid = f_valid;
  assign in_ready   = !f_valid || push_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      f_valid <= 1'b1;
    end else if (push_ready) begin
      f_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      f_hit <= surface_hit;
      f_cam <= camera_ray;
      f_n   <= normal_vec;
      f_p   <= hit_point_vec;
      f_tu  <= tangent_u_vec;
      f_tv  <= tangent_v_vec;
      f_ox  <= x_ray_origin_vec;
      f_dx  <= x_ray_dir_vec;
      f_oy  <= y_ray_origin_vec;
      f_dy  <= y_ray_dir_vec;
    end
  end

  rdu_pkg::comp_t nv [3];
  rdu_pkg::comp_t pv [3];
  rdu_pkg::comp_t oxv [3];
  rdu_pkg::comp_t dxv [3];
  rdu_pkg::comp_t oyv [3];
  rdu_pkg::comp_t dyv [3];
  logic signed [CB:0] pmx [3];
  logic signed [CB:0] pmy [3];
  logic signed [rdu_pkg::DOT_BITS-1:0]  den_x, den_y;
  logic signed [rdu_pkg::NUMT_BITS-1:0] numt_x, numt_y;
  rdu_pkg::axis_t axis;

  // Dot products of the normal with each ray direction and with P minus O.
  always_comb begin
    den_x  = '0;
    den_y  = '0;
    numt_x = '0;
    numt_y = '0;
    for (int k = 0; k < 3; k++) begin
      nv[k]  = rdu_pkg::get_comp(f_n, 2'(k));
      pv[k]  = rdu_pkg::get_comp(f_p, 2'(k));
      oxv[k] = rdu_pkg::get_comp(f_ox, 2'(k));
      dxv[k] = rdu_pkg::get_comp(f_dx, 2'(k));
      oyv[k] = rdu_pkg::get_comp(f_oy, 2'(k));
      dyv[k] = rdu_pkg::get_comp(f_dy, 2'(k));
      pmx[k] = (CB+1)'(pv[k]) - (CB+1)'(oxv[k]);
      pmy[k] = (CB+1)'(pv[k]) - (CB+1)'(oyv[k]);
      den_x  = den_x + rdu_pkg::DOT_BITS'(nv[k]) * rdu_pkg::DOT_BITS'(dxv[k]);
      den_y  = den_y + rdu_pkg::DOT_BITS'(nv[k]) * rdu_pkg::DOT_BITS'(dyv[k]);
      numt_x = numt_x + rdu_pkg::NUMT_BITS'(nv[k]) * rdu_pkg::NUMT_BITS'(pmx[k]);
      numt_y = numt_y + rdu_pkg::NUMT_BITS'(nv[k]) * rdu_pkg::NUMT_BITS'(pmy[k]);
    end
  end

  // The first of the z and y normal components whose magnitude reaches the tolerance picks the plane; else YZ.
  always_comb begin
    priority if ({1'b0, rdu_pkg::comp_mag(nv[2])} >= (CB+1)'(tol)) begin
      axis = rdu_pkg::AXIS_XY;
    end else if ({1'b0, rdu_pkg::comp_mag(nv[1])} >= (CB+1)'(tol)) begin
      axis = rdu_pkg::AXIS_XZ;
    end else begin
      axis = rdu_pkg::AXIS_YZ;
    end
  end

  always_comb begin
    item.active  = f_hit && f_cam;
    item.p0      = rdu_pkg::pick(f_p, axis, 1'b0);
    item.p1      = rdu_pkg::pick(f_p, axis, 1'b1);
    item.tu0     = rdu_pkg::pick(f_tu, axis, 1'b0);
    item.tu1     = rdu_pkg::pick(f_tu, axis, 1'b1);
    item.tv0     = rdu_pkg::pick(f_tv, axis, 1'b0);
    item.tv1     = rdu_pkg::pick(f_tv, axis, 1'b1);
    item.rx.o0   = rdu_pkg::pick(f_ox, axis, 1'b0);
    item.rx.o1   = rdu_pkg::pick(f_ox, axis, 1'b1);
    item.rx.d0   = rdu_pkg::pick(f_dx, axis, 1'b0);
    item.rx.d1   = rdu_pkg::pick(f_dx, axis, 1'b1);
    item.rx.den  = den_x;
    item.rx.numt = numt_x;
    item.ry.o0   = rdu_pkg::pick(f_oy, axis, 1'b0);
    item.ry.o1   = rdu_pkg::pick(f_oy, axis, 1'b1);
    item.ry.d0   = rdu_pkg::pick(f_dy, axis, 1'b0);
    item.ry.d1   = rdu_pkg::pick(f_dy, axis, 1'b1);
    item.ry.den  = den_y;
    item.ry.numt = numt_y;
  end

endmodule

>>> src/rdu_queue.sv
// Small register FIFO between the front end and the back end.
module rdu_queue #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         wr_valid,
  output logic         wr_ready,
  input  logic [W-1:0] wr_data,
  output logic         rd_valid,
  input  logic         rd_ready,
  output logic [W-1:0] rd_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign wr_ready = count != CNT_W'(DEPTH);
  assign rd_valid = count != '0;
  assign rd_data  = mem[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

>>> src/rdu_back.sv
// Back end: ray parameters, offset vectors, the 2x2 solve and the result register.
module rdu_back (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                pop_valid,
  output logic                                pop_ready,
  input  rdu_pkg::item_t                      item,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                derivs_valid,
  output logic signed [rdu_pkg::RES_BITS-1:0] du_per_x,
  output logic signed [rdu_pkg::RES_BITS-1:0] dv_per_x,
  output logic signed [rdu_pkg::RES_BITS-1:0] du_per_y,
  output logic signed [rdu_pkg::RES_BITS-1:0] dv_per_y
);

  localparam int CB   = rdu_pkg::COMP_BITS;
  localparam int PD   = rdu_pkg::PD_BITS;
  localparam int OB   = rdu_pkg::OFF_BITS;
  localparam int NP   = rdu_pkg::NP_BITS;
  localparam int RN   = rdu_pkg::RNUM_BITS;
  localparam int DB   = rdu_pkg::DET_BITS;
  localparam int TS_W = $bits(rdu_pkg::tside_t);

  // The whole back end moves together; it halts only while a result waits.
  logic en;
  assign en        = !out_valid || out_ready;
  assign pop_ready = en;

  // Stage 0: registered queue head.
  logic           s0_valid;
  rdu_pkg::item_t s0;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (en) begin
      s0_valid <= pop_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0 <= item;
    end
  end

  logic [rdu_pkg::NUMT_BITS-1:0] tx_a, ty_a;
  logic [rdu_pkg::DOT_BITS-1:0]  tx_b, ty_b;
  logic                          tx_neg, ty_neg;
  rdu_pkg::tside_t               ts_in;

  always_comb begin
    tx_a   = s0.rx.numt[rdu_pkg::NUMT_BITS-1] ? rdu_pkg::NUMT_BITS'(-s0.rx.numt)
                                              : rdu_pkg::NUMT_BITS'(s0.rx.numt);
    ty_a   = s0.ry.numt[rdu_pkg::NUMT_BITS-1] ? rdu_pkg::NUMT_BITS'(-s0.ry.numt)
                                              : rdu_pkg::NUMT_BITS'(s0.ry.numt);
    tx_b   = s0.rx.den[rdu_pkg::DOT_BITS-1] ? rdu_pkg::DOT_BITS'(-s0.rx.den)
                                            : rdu_pkg::DOT_BITS'(s0.rx.den);
    ty_b   = s0.ry.den[rdu_pkg::DOT_BITS-1] ? rdu_pkg::DOT_BITS'(-s0.ry.den)
                                            : rdu_pkg::DOT_BITS'(s0.ry.den);
    tx_neg = s0.rx.numt[rdu_pkg::NUMT_BITS-1] ^ s0.rx.den[rdu_pkg::DOT_BITS-1];
    ty_neg = s0.ry.numt[rdu_pkg::NUMT_BITS-1] ^ s0.ry.den[rdu_pkg::DOT_BITS-1];
    ts_in.active = s0.active;
    ts_in.par_x  = s0.rx.den == '0;
    ts_in.p0     = s0.p0;
    ts_in.p1     = s0.p1;
    ts_in.tu0    = s0.tu0;
    ts_in.tu1    = s0.tu1;
    ts_in.tv0    = s0.tv0;
    ts_in.tv1    = s0.tv1;
    ts_in.ox0    = s0.rx.o0;
    ts_in.ox1    = s0.rx.o1;
    ts_in.dx0    = s0.rx.d0;
    ts_in.dx1    = s0.rx.d1;
    ts_in.oy0    = s0.ry.o0;
    ts_in.oy1    = s0.ry.o1;
    ts_in.dy0    = s0.ry.d0;
    ts_in.dy1    = s0.ry.d1;
  end

  logic                               tdiv_valid;
  logic signed [rdu_pkg::T_BITS-1:0]  tx, ty;
  logic [TS_W-1:0]                    ts_raw;
  rdu_pkg::tside_t                    ts;
  logic                               par_y;

  rdu_div #(
    .A_W(rdu_pkg::NUMT_BITS), .B_W(rdu_pkg::DOT_BITS), .Q_W(rdu_pkg::T_QBITS),
    .FRAC(rdu_pkg::T_FRAC), .SIDE_W(TS_W)
  ) u_tdiv_x (
    .clk, .rst, .en,
    .in_valid(s0_valid), .a(tx_a), .b(tx_b), .neg(tx_neg), .side(ts_in),
    .out_valid(tdiv_valid), .q(tx), .out_side(ts_raw)
  );

  rdu_div #(
    .A_W(rdu_pkg::NUMT_BITS), .B_W(rdu_pkg::DOT_BITS), .Q_W(rdu_pkg::T_QBITS),
    .FRAC(rdu_pkg::T_FRAC), .SIDE_W(1)
  ) u_tdiv_y (
    .clk, .rst, .en,
    .in_valid(s0_valid), .a(ty_a), .b(ty_b), .neg(ty_neg), .side(s0.ry.den == '0),
    .out_valid(), .q(ty), .out_side(par_y)
  );

  assign ts = rdu_pkg::tside_t'(ts_raw);

  // Stage 1: direction times t, and the determinant products.
  logic                   s1_valid;
  logic signed [PD-1:0]   s1_px0, s1_px1, s1_py0, s1_py1;
  logic signed [2*CB-1:0] s1_da, s1_db;
  rdu_pkg::tside_t        s1_ts;
  logic                   s1_par_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= tdiv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_px0   <= PD'(ts.dx0) * PD'(tx);
      s1_px1   <= PD'(ts.dx1) * PD'(tx);
      s1_py0   <= PD'(ts.dy0) * PD'(ty);
      s1_py1   <= PD'(ts.dy1) * PD'(ty);
      s1_da    <= (2*CB)'(ts.tu0) * (2*CB)'(ts.tv1);
      s1_db    <= (2*CB)'(ts.tu1) * (2*CB)'(ts.tv0);
      s1_ts    <= ts;
      s1_par_y <= par_y;
    end
  end

  // Stage 2: offset vectors. D*t is truncated toward zero before it is added.
  logic signed [PD-1:0] adj_x0, adj_x1, adj_y0, adj_y1;
  logic signed [OB-1:0] ex0_n, ex1_n, ey0_n, ey1_n;
  localparam logic signed [PD-1:0] RND = PD'((64'd1 << rdu_pkg::T_FRAC) - 64'd1);

  always_comb begin
    adj_x0 = s1_px0 + (s1_px0[PD-1] ? RND : '0);
    adj_x1 = s1_px1 + (s1_px1[PD-1] ? RND : '0);
    adj_y0 = s1_py0 + (s1_py0[PD-1] ? RND : '0);
    adj_y1 = s1_py1 + (s1_py1[PD-1] ? RND : '0);
    // A ray parallel to the plane lands on the origin, so its offset is minus P.
    ex0_n = s1_ts.par_x ? -OB'(s1_ts.p0)
          : OB'(s1_ts.ox0) - OB'(s1_ts.p0) + OB'(adj_x0 >>> rdu_pkg::T_FRAC);
    ex1_n = s1_ts.par_x ? -OB'(s1_ts.p1)
          : OB'(s1_ts.ox1) - OB'(s1_ts.p1) + OB'(adj_x1 >>> rdu_pkg::T_FRAC);
    ey0_n = s1_par_y ? -OB'(s1_ts.p0)
          : OB'(s1_ts.oy0) - OB'(s1_ts.p0) + OB'(adj_y0 >>> rdu_pkg::T_FRAC);
    ey1_n = s1_par_y ? -OB'(s1_ts.p1)
          : OB'(s1_ts.oy1) - OB'(s1_ts.p1) + OB'(adj_y1 >>> rdu_pkg::T_FRAC);
  end

  logic                 s2_valid;
  logic                 s2_active;
  logic signed [OB-1:0] s2_ex0, s2_ex1, s2_ey0, s2_ey1;
  logic signed [DB-1:0] s2_det;
  rdu_pkg::comp_t       s2_tu0, s2_tu1, s2_tv0, s2_tv1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_active <= s1_ts.active;
      s2_ex0    <= ex0_n;
      s2_ex1    <= ex1_n;
      s2_ey0    <= ey0_n;
      s2_ey1    <= ey1_n;
      s2_det    <= DB'(s1_da) - DB'(s1_db);
      s2_tu0    <= s1_ts.tu0;
      s2_tu1    <= s1_ts.tu1;
      s2_tv0    <= s1_ts.tv0;
      s2_tv1    <= s1_ts.tv1;
    end
  end

  // Stage 3: Cramer's rule products.
  logic                 s3_valid;
  logic                 s3_active;
  logic signed [NP-1:0] s3_m [8];
  logic signed [DB-1:0] s3_det;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (en) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_active <= s2_active;
      s3_det    <= s2_det;
      s3_m[0]   <= NP'(s2_ex0) * NP'(s2_tv1);
      s3_m[1]   <= NP'(s2_ex1) * NP'(s2_tv0);
      s3_m[2]   <= NP'(s2_ex1) * NP'(s2_tu0);
      s3_m[3]   <= NP'(s2_ex0) * NP'(s2_tu1);
      s3_m[4]   <= NP'(s2_ey0) * NP'(s2_tv1);
      s3_m[5]   <= NP'(s2_ey1) * NP'(s2_tv0);
      s3_m[6]   <= NP'(s2_ey1) * NP'(s2_tu0);
      s3_m[7]   <= NP'(s2_ey0) * NP'(s2_tu1);
    end
  end

  // Stage 4: numerators and the zero-determinant check.
  logic                 s4_valid;
  logic                 s4_ok;
  logic signed [RN-1:0] s4_res [4];
  logic signed [DB-1:0] s4_det;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (en) begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_ok  <= s3_active && (s3_det != '0);
      s4_det <= s3_det;
      for (int k = 0; k < 4; k++) begin
        s4_res[k] <= RN'(s3_m[2*k]) - RN'(s3_m[2*k+1]);
      end
    end
  end

  logic [DB-1:0] det_mag;
  assign det_mag = s4_det[DB-1] ? DB'(-s4_det) : DB'(s4_det);

  logic                                  ddiv_valid;
  logic                                  ddiv_ok;
  logic signed [rdu_pkg::RES_BITS-1:0]   dq [4];

  for (genvar k = 0; k < 4; k++) begin : g_ddiv
    logic [RN-1:0] num_mag;
    assign num_mag = s4_res[k][RN-1] ? RN'(-s4_res[k]) : RN'(s4_res[k]);

    if (k == 0) begin : g_lead
      rdu_div #(
        .A_W(RN), .B_W(DB), .Q_W(rdu_pkg::RES_QBITS),
        .FRAC(rdu_pkg::RES_FRAC), .SIDE_W(1)
      ) u_ddiv (
        .clk, .rst, .en,
        .in_valid(s4_valid), .a(num_mag), .b(det_mag),
        .neg(s4_res[k][RN-1] ^ s4_det[DB-1]), .side(s4_ok),
        .out_valid(ddiv_valid), .q(dq[k]), .out_side(ddiv_ok)
      );
    end else begin : g_rest
      rdu_div #(
        .A_W(RN), .B_W(DB), .Q_W(rdu_pkg::RES_QBITS),
        .FRAC(rdu_pkg::RES_FRAC), .SIDE_W(1)
      ) u_ddiv (
        .clk, .rst, .en,
        .in_valid(s4_valid), .a(num_mag), .b(det_mag),
        .neg(s4_res[k][RN-1] ^ s4_det[DB-1]), .side(s4_ok),
        .out_valid(), .q(dq[k]), .out_side()
      );
    end
  end

  // Result register; a word that could not be solved carries zero derivatives.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= ddiv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      derivs_valid <= ddiv_ok;
      du_per_x     <= ddiv_ok ? dq[0] : '0;
      dv_per_x     <= ddiv_ok ? dq[1] : '0;
      du_per_y     <= ddiv_ok ? dq[2] : '0;
      dv_per_y     <= ddiv_ok ? dq[3] : '0;
    end
  end

endmodule

>>> dv/ray_differential_uv_derivatives_checker.sv
// Checker for the ray differential UV derivative block: predicts and compares result words.
`timescale 1ns / 100ps

module ray_differential_uv_derivatives_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [rdu_pkg::TOL_BITS-1:0]        cfg_data,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic                                surface_hit,
  input  logic                                camera_ray,
  input  logic [rdu_pkg::VEC_BITS-1:0]        normal_vec,
  input  logic [rdu_pkg::VEC_BITS-1:0]        hit_point_vec,
  input  logic [rdu_pkg::VEC_BITS-1:0]        tangent_u_vec,
  input  logic [rdu_pkg::VEC_BITS-1:0]        tangent_v_vec,
  input  logic [rdu_pkg::VEC_BITS-1:0]        x_ray_origin_vec,
  input  logic [rdu_pkg::VEC_BITS-1:0]        x_ray_dir_vec,
  input  logic [rdu_pkg::VEC_BITS-1:0]        y_ray_origin_vec,
  input  logic [rdu_pkg::VEC_BITS-1:0]        y_ray_dir_vec,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic                                derivs_valid,
  input  logic signed [rdu_pkg::RES_BITS-1:0] du_per_x,
  input  logic signed [rdu_pkg::RES_BITS-1:0] dv_per_x,
  input  logic signed [rdu_pkg::RES_BITS-1:0] du_per_y,
  input  logic signed [rdu_pkg::RES_BITS-1:0] dv_per_y,
  output int                                  fail_count,
  output int                                  pending,
  output int                                  solved_count
);

  localparam longint OFFSET_LIMIT = 64'hFF_FFFF_FFFF;
  localparam longint DERIV_LIMIT  = 64'h7FFF_FFFF;

  typedef struct {
    bit                                solved;
    bit signed [rdu_pkg::RES_BITS-1:0] d[4];
  } uv_derivs_t;

  uv_derivs_t                   derivs_due[$];
  bit [rdu_pkg::TOL_BITS-1:0]   tolerance;

  function automatic longint component(bit [rdu_pkg::VEC_BITS-1:0] v, int k);
    bit signed [rdu_pkg::COMP_BITS-1:0] c;
    c = v[k*rdu_pkg::COMP_BITS +: rdu_pkg::COMP_BITS];
    return longint'(c);
  endfunction

  function automatic longint unsigned magnitude(longint v);
    return v < 0 ? longint'(0) - v : v;
  endfunction

  // Truncating fixed-point quotient num * 2^frac / den, saturated to +-lim.
  function automatic longint fixed_quotient(longint num, longint den, int frac, longint lim);
    longint unsigned a, b, q, r, ul;
    bit neg;
    int i;
    a = magnitude(num);
    b = magnitude(den);
    ul = lim;
    neg = (num < 0) != (den < 0);
    q = a / b;
    r = a % b;
    if (q > ul) q = ul;
    i = 0;
    while (i < frac && q < ul) begin
      q = q << 1;
      r = r << 1;
      if (r >= b) begin
        r = r - b;
        q = q + 1;
      end
      if (q > ul) q = ul;
      i++;
    end
    if (i < frac) q = ul;
    return neg ? -longint'(q) : longint'(q);
  endfunction

  // Offset point of one ray on the tangent plane, minus the hit point.
  function automatic void plane_offset(longint n[3], longint p[3],
                                       bit [rdu_pkg::VEC_BITS-1:0] ov,
                                       bit [rdu_pkg::VEC_BITS-1:0] dv, output longint e[3]);
    longint o[3], d[3], den, num, t, s;
    for (int k = 0; k < 3; k++) begin
      o[k] = component(ov, k);
      d[k] = component(dv, k);
    end
    den = n[0]*d[0] + n[1]*d[1] + n[2]*d[2];
    if (den == 0) begin
      // A ray parallel to the plane gives the origin as offset point.
      for (int k = 0; k < 3; k++) e[k] = -p[k];
      return;
    end
    num = n[0]*(p[0]-o[0]) + n[1]*(p[1]-o[1]) + n[2]*(p[2]-o[2]);
    t = fixed_quotient(num, den, 2*rdu_pkg::COMP_FRAC, OFFSET_LIMIT);
    for (int k = 0; k < 3; k++) begin
      s = (d[k] * t) / (longint'(1) << (2*rdu_pkg::COMP_FRAC));
      s = o[k] - p[k] + s;
      if (s > OFFSET_LIMIT) s = OFFSET_LIMIT;
      if (s < -OFFSET_LIMIT) s = -OFFSET_LIMIT;
      e[k] = s;
    end
  endfunction

  function automatic uv_derivs_t predict_derivs();
    uv_derivs_t res;
    longint n[3], p[3], tu[3], tv[3], ex[3], ey[3], det, num[4];
    rdu_pkg::axis_t axis;
    int a0, a1;
    res.solved = 0;
    for (int k = 0; k < 4; k++) res.d[k] = '0;
    if (!surface_hit || !camera_ray) return res;
    for (int k = 0; k < 3; k++) begin
      n[k]  = component(normal_vec, k);
      p[k]  = component(hit_point_vec, k);
      tu[k] = component(tangent_u_vec, k);
      tv[k] = component(tangent_v_vec, k);
    end
    plane_offset(n, p, x_ray_origin_vec, x_ray_dir_vec, ex);
    plane_offset(n, p, y_ray_origin_vec, y_ray_dir_vec, ey);
    if (magnitude(n[2]) >= tolerance) axis = rdu_pkg::AXIS_XY;
    else if (magnitude(n[1]) >= tolerance) axis = rdu_pkg::AXIS_XZ;
    else axis = rdu_pkg::AXIS_YZ;
    case (axis)
      rdu_pkg::AXIS_XY: begin a0 = 0; a1 = 1; end
      rdu_pkg::AXIS_XZ: begin a0 = 0; a1 = 2; end
      default: begin a0 = 1; a1 = 2; end
    endcase
    det = tu[a0]*tv[a1] - tu[a1]*tv[a0];
    if (det == 0) return res;
    num[0] = ex[a0]*tv[a1] - ex[a1]*tv[a0];
    num[1] = ex[a1]*tu[a0] - ex[a0]*tu[a1];
    num[2] = ey[a0]*tv[a1] - ey[a1]*tv[a0];
    num[3] = ey[a1]*tu[a0] - ey[a0]*tu[a1];
    res.solved = 1;
    for (int k = 0; k < 4; k++)
      res.d[k] = rdu_pkg::RES_BITS'(fixed_quotient(num[k], det, rdu_pkg::RES_FRAC,
                                                   DERIV_LIMIT));
    return res;
  endfunction

  always @(posedge clk) begin
    uv_derivs_t want;
    bit signed [rdu_pkg::RES_BITS-1:0] seen[4];
    if (rst) begin
      tolerance = rdu_pkg::TOL_RESET;
      derivs_due.delete();
      fail_count = 0;
      solved_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) tolerance = cfg_data;
      if (in_valid && in_ready) derivs_due.push_back(predict_derivs());
      if (out_valid && out_ready) begin
        if (derivs_due.size() == 0) begin
          $display("%0t: result word with nothing expected", $time);
          fail_count++;
        end else begin
          want = derivs_due.pop_front();
          seen = '{du_per_x, dv_per_x, du_per_y, dv_per_y};
          if (derivs_valid) solved_count++;
          if (derivs_valid !== want.solved) begin
            $display("%0t: derivs_valid expected %0d actual %0b", $time, want.solved,
                     derivs_valid);
            fail_count++;
          end
          for (int k = 0; k < 4; k++)
            if (seen[k] !== want.d[k]) begin
              $display("%0t: derivative %0d expected %0d actual %0d", $time, k,
                       want.d[k], seen[k]);
              fail_count++;
            end
        end
      end
    end
    pending = derivs_due.size();
  end

  initial begin
    fail_count = 0;
    pending = 0;
    solved_count = 0;
    tolerance = rdu_pkg::TOL_RESET;
  end

endmodule

>>> dv/ray_differential_uv_derivatives_tb.sv
// Testbench top for the ray differential UV derivative block: stimulus and verdict.
`timescale 1ns / 100ps

module ray_differential_uv_derivatives_tb;

  localparam int ONE = 1 << rdu_pkg::COMP_FRAC;  // 1.0 in Q8.12

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [rdu_pkg::TOL_BITS-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic surface_hit = 1'b0;
  logic camera_ray = 1'b0;
  logic [rdu_pkg::VEC_BITS-1:0] normal_vec = '0, hit_point_vec = '0, tangent_u_vec = '0;
  logic [rdu_pkg::VEC_BITS-1:0] tangent_v_vec = '0, x_ray_origin_vec = '0;
  logic [rdu_pkg::VEC_BITS-1:0] x_ray_dir_vec = '0;
  logic [rdu_pkg::VEC_BITS-1:0] y_ray_origin_vec = '0, y_ray_dir_vec = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic derivs_valid;
  logic signed [rdu_pkg::RES_BITS-1:0] du_per_x, dv_per_x, du_per_y, dv_per_y;

  int fail_count, pending, solved_count;
  int words_sent = 0;
  int stall_pct = 0;       // receiver stall rate in percent, zero for none
  bit gaps_on = 0;         // sender gaps between bursts
  int burst_left = 0;

  typedef struct {
    bit hit, cam;
    bit [rdu_pkg::VEC_BITS-1:0] n, p, tu, tv, xo, xd, yo, yd;
  } hit_word_t;

  // The clock runs at 2 ns.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  ray_differential_uv_derivatives dut (.*);

  ray_differential_uv_derivatives_checker u_checker (.*);

  // The receiver stalls at the random rate of the current phase, except that every
  // fourth window, while bits 7:6 of the cycle counter are both set, runs without any stall.
  int rx_cycle = 0;
  always @(negedge clk) begin
    rx_cycle++;
    if (stall_pct == 0 || rx_cycle[7:6] == 2'd3) out_ready = 1'b1;
    else out_ready = $urandom_range(0, 99) >= stall_pct;
  end

  function automatic bit [rdu_pkg::VEC_BITS-1:0] vec3(int x, int y, int z);
    return {rdu_pkg::COMP_BITS'(z), rdu_pkg::COMP_BITS'(y), rdu_pkg::COMP_BITS'(x)};
  endfunction

  // Random vector with components within +-span, or raw random bits if span is zero.
  function automatic bit [rdu_pkg::VEC_BITS-1:0] rand_vec(int span);
    bit [63:0] raw;
    raw = {$urandom, $urandom};
    if (span == 0) return raw[rdu_pkg::VEC_BITS-1:0];
    return vec3($urandom_range(0, 2*span) - span, $urandom_range(0, 2*span) - span,
                $urandom_range(0, 2*span) - span);
  endfunction

  // Drive one hit word at the falling edge and hold it until it is accepted.
  task automatic send_hit(hit_word_t w);
    int gap;
    surface_hit = w.hit;      camera_ray = w.cam;
    normal_vec = w.n;         hit_point_vec = w.p;
    tangent_u_vec = w.tu;     tangent_v_vec = w.tv;
    x_ray_origin_vec = w.xo;  x_ray_dir_vec = w.xd;
    y_ray_origin_vec = w.yo;  y_ray_dir_vec = w.yd;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    words_sent++;
    // Bursts of random length, separated by random idle gaps.
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = gaps_on ? $urandom_range(0, 12) : 0;
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end else burst_left--;
  endtask

  task automatic write_tolerance(int value);
    cfg_data = rdu_pkg::TOL_BITS'(value);
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  // A well-formed hit: a dominant normal axis, random tangents, and offset rays whose
  // origins are the hit point with random bits flipped and whose directions are random.
  function automatic hit_word_t plausible_hit(int span);
    hit_word_t w;
    int ax;
    int nc[3];
    ax = $urandom_range(0, 2);
    for (int k = 0; k < 3; k++) nc[k] = $urandom_range(0, 2*span/8) - span/8;
    nc[ax] = ($urandom_range(0, 1) ? 1 : -1) * $urandom_range(ONE/2, 2*ONE);
    w.hit = $urandom_range(0, 19) != 0;
    w.cam = $urandom_range(0, 19) != 0;
    w.n = vec3(nc[0], nc[1], nc[2]);
    w.p = rand_vec(span * 4);
    w.tu = rand_vec(span);
    w.tv = rand_vec(span);
    w.xo = w.p ^ rand_vec(span / 4);
    w.yo = w.p ^ rand_vec(span / 4);
    w.xd = rand_vec(span);
    w.yd = rand_vec(span);
    return w;
  endfunction

  function automatic hit_word_t noise_hit();
    hit_word_t w;
    w.hit = $urandom_range(0, 1);
    w.cam = $urandom_range(0, 1);
    w.n = rand_vec(0);   w.p = rand_vec(0);
    w.tu = rand_vec(0);  w.tv = rand_vec(0);
    w.xo = rand_vec(0);  w.xd = rand_vec(0);
    w.yo = rand_vec(0);  w.yd = rand_vec(0);
    return w;
  endfunction

  task automatic directed_hits();
    hit_word_t base, w;
    int maxc, minc;
    maxc = (1 << (rdu_pkg::COMP_BITS-1)) - 1;
    minc = -(1 << (rdu_pkg::COMP_BITS-1));
    // A flat floor facing +z, unit tangents, rays falling straight or nearly straight down.
    base.hit = 1; base.cam = 1;
    base.n = vec3(0, 0, ONE);          base.p = vec3(ONE, 2*ONE, 0);
    base.tu = vec3(ONE, 0, 0);         base.tv = vec3(0, ONE, 0);
    base.xo = vec3(ONE + 40, 2*ONE, ONE);   base.xd = vec3(0, 0, -ONE);
    base.yo = vec3(ONE, 2*ONE + 40, ONE);   base.yd = vec3(5, 3, -ONE);
    send_hit(base);
    w = base; w.hit = 0; send_hit(w);          // no hit
    w = base; w.cam = 0; send_hit(w);          // not a camera ray
    w = base; w.hit = 0; w.cam = 0; send_hit(w);
    w = base; w.tv = w.tu; send_hit(w);        // zero determinant
    w = base; w.xd = vec3(ONE, 0, 0); send_hit(w);      // x ray parallel
    w = base; w.yd = vec3(0, ONE, 0); send_hit(w);      // y ray parallel
    w = base; w.xd = vec3(ONE, 0, 0); w.yd = vec3(ONE, ONE, 0); send_hit(w);
    // Axis choice: normal dominant in y, then in x.
    w = base; w.n = vec3(0, ONE, 0); w.tv = vec3(0, 0, ONE);
    w.xd = vec3(0, -ONE, 0); w.yd = vec3(3, -ONE, 7); send_hit(w);
    w = base; w.n = vec3(ONE, 0, 0); w.tu = vec3(0, ONE, 0); w.tv = vec3(0, 0, ONE);
    w.xd = vec3(-ONE, 0, 0); w.yd = vec3(-ONE, 9, 2); send_hit(w);
    w = base; w.n = vec3(0, 0, 0); send_hit(w);         // degenerate normal
    // Saturation: a tiny determinant, then huge offsets.
    w = base; w.tu = vec3(1, 0, 0); w.tv = vec3(0, 1, 0); send_hit(w);
    w = base; w.xd = vec3(maxc, maxc, 1); w.yd = vec3(minc, maxc, -1); send_hit(w);
    w = base; w.xd = vec3(minc, minc, -1); send_hit(w);
    // Field extremes.
    w = base; w.n = vec3(maxc, maxc, maxc); w.p = vec3(minc, minc, minc);
    w.tu = vec3(maxc, minc, maxc); w.tv = vec3(minc, maxc, 1); send_hit(w);
    w.xo = {rdu_pkg::VEC_BITS{1'b1}}; w.xd = {rdu_pkg::VEC_BITS{1'b1}};
    w.yo = vec3(maxc, maxc, maxc); w.yd = vec3(minc, minc, minc); send_hit(w);
    w = base; w.n = '0; w.p = '0; w.tu = '0; w.tv = '0; send_hit(w);
    w = base; w.n = {rdu_pkg::VEC_BITS{1'b1}}; w.p = {rdu_pkg::VEC_BITS{1'b1}};
    w.tu = {rdu_pkg::VEC_BITS{1'b1}}; w.tv = vec3(1, -1, 2); send_hit(w);
    // Normal components right at the tolerance edge.
    w = base; w.n = vec3(ONE, 1, 1); send_hit(w);
    w = base; w.n = vec3(ONE, 0, 1); w.tv = vec3(0, 0, ONE); send_hit(w);
    w = base; w.n = vec3(ONE, 1, 0); w.tv = vec3(3, 0, ONE); send_hit(w);
  endtask

  task automatic random_hits(int count);
    int pick, span;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      // Mostly small sizes, sometimes full scale.
      span = $urandom_range(0, 9) == 0 ? 200000 : $urandom_range(8, 3*ONE);
      if (pick < 75) send_hit(plausible_hit(span));
      else send_hit(noise_hit());
    end
  endtask

  initial begin
    int tolerances[5];
    tolerances = '{0, 524287, 1, 0, 2*ONE};
    tolerances[3] = $urandom_range(2, ONE);
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    // First a pass at the reset tolerance.
    directed_hits();
    random_hits(150);
    drain();
    for (int ph = 0; ph < 5; ph++) begin
      write_tolerance(tolerances[ph]);
      gaps_on = ph[0];
      stall_pct = (ph == 2) ? 0 : $urandom_range(10, 70);
      directed_hits();
      random_hits(350);
      drain();
    end
    $display("Sent %0d hit words over six tolerance settings; %0d gave derivatives.",
             words_sent, solved_count);
    if (fail_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

endmodule
